>>> rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Shared constants and types for the sigma-delta motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

    localparam int PIXELS = 65536;
    localparam int ADDR_W = $clog2(PIXELS);

    localparam int INDEX_W = 16;
    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 4;
    localparam int PROD_W  = GAIN_W + PIX_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_MAX = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET    = 4'd3;
    localparam logic [PIX_W-1:0]  VAR_MIN_RESET = 8'd1;
    localparam logic [PIX_W-1:0]  VAR_MAX_RESET = 8'd254;

    // one entry of the per-pixel state memory
    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic [PIX_W-1:0] variance;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/sigma_delta_motion_detect.sv
// ----------------------------------------------------------------------------
// sigma_delta_motion_detect
// Per-pixel sigma-delta background subtraction with mean/variance in RAM.
// ----------------------------------------------------------------------------
//  channel   ports                      direction  handshake
//  s_        pixel_index/value, first   in         s_valid / s_ready
//  m_        motion, difference, mean,  out        m_valid / m_ready
//            variance
//  cfg_      cfg_index, cfg_data        in         cfg_we (no wait)
//
// One item per clock sustained while m_ready stays high. m_valid rises
// when the update stage advances: the state RAM is read at the accepting
// edge, and the update lands in the output register as the entry is
// written back. A back-to-back item on the same pixel takes the written
// entry by a forwarding register. m_ready low holds the output register
// and the update stage; s_ready drops only when both are full. Reset clears
// the valid and forward-hit flags and the configuration, not the state RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_delta_motion_detect (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 cfg_we,
    input  wire  [smd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [smd_pkg::PIX_W-1:0]           cfg_data,

    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [smd_pkg::INDEX_W-1:0]         s_pixel_index,
    input  wire  [smd_pkg::PIX_W-1:0]           s_pixel_value,
    input  wire                                 s_first_frame,

    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic                                m_motion,
    output logic [smd_pkg::PIX_W-1:0]           m_difference,
    output logic [smd_pkg::PIX_W-1:0]           m_mean_out,
    output logic [smd_pkg::PIX_W-1:0]           m_variance_out
);
    import smd_pkg::*;

    // configuration
    logic [GAIN_W-1:0] gain_reg;
    logic [PIX_W-1:0]  var_min_reg;
    logic [PIX_W-1:0]  var_max_reg;

    // state memory
    entry_t            mem [PIXELS];
    entry_t            rd_data_reg;

    // update stage
    logic              u_valid_reg;
    logic [ADDR_W-1:0] u_addr_reg;
    logic [PIX_W-1:0]  u_pix_reg;
    logic              u_first_reg;
    logic              fwd_hit_reg;
    entry_t            fwd_data_reg;

    // output register
    logic              o_valid_reg;
    logic              o_motion_reg;
    logic [PIX_W-1:0]  o_diff_reg;
    logic [PIX_W-1:0]  o_mean_reg;
    logic [PIX_W-1:0]  o_var_reg;

    logic              s_accept;
    logic              u_advance;
    logic [ADDR_W-1:0] in_addr;

    entry_t            old_entry;
    entry_t            new_entry;
    logic [PIX_W-1:0]  mean_step;
    logic [PIX_W-1:0]  diff;
    logic [PROD_W-1:0] target;
    logic [PIX_W:0]    var_step;
    logic [PIX_W:0]    var_hi;
    logic [PIX_W-1:0]  var_clamp;
    logic              motion;

    assign in_addr   = s_pixel_index[ADDR_W-1:0];
    assign u_advance = u_valid_reg && (!o_valid_reg || m_ready);
    assign s_ready   = !u_valid_reg || u_advance;
    assign s_accept  = s_valid && s_ready;

    // update of one entry
    always_comb begin
        old_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

        if (u_pix_reg > old_entry.mean) begin
            mean_step = old_entry.mean + 8'd1;
        end else if (u_pix_reg < old_entry.mean) begin
            mean_step = old_entry.mean - 8'd1;
        end else begin
            mean_step = old_entry.mean;
        end

        diff   = (mean_step > u_pix_reg) ? (mean_step - u_pix_reg)
                                         : (u_pix_reg - mean_step);
        target = gain_reg * diff;

        // done at 9 bits so 255 + 1 does not wrap
        if (target > {{(PROD_W-PIX_W){1'b0}}, old_entry.variance}) begin
            var_step = {1'b0, old_entry.variance} + 9'd1;
        end else if (target < {{(PROD_W-PIX_W){1'b0}}, old_entry.variance}) begin
            var_step = {1'b0, old_entry.variance} - 9'd1;
        end else begin
            var_step = {1'b0, old_entry.variance};
        end

        var_hi    = (var_step > {1'b0, var_max_reg}) ? {1'b0, var_max_reg} : var_step;
        // lower clamp last: wins when the limits cross
        var_clamp = (var_hi < {1'b0, var_min_reg}) ? var_min_reg : var_hi[PIX_W-1:0];

        if (u_first_reg) begin
            new_entry.mean     = u_pix_reg;
            new_entry.variance = var_min_reg;
            motion             = 1'b0;
        end else begin
            new_entry.mean     = mean_step;
            new_entry.variance = var_clamp;
            motion             = (diff >= var_clamp);
        end
    end

    // state RAM: one write, one registered read
    always_ff @(posedge aclk) begin
        if (u_advance) begin
            mem[u_addr_reg] <= new_entry;
        end
        if (s_accept) begin
            rd_data_reg <= mem[in_addr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            u_addr_reg   <= in_addr;
            u_pix_reg    <= s_pixel_value;
            u_first_reg  <= s_first_frame;
            fwd_data_reg <= new_entry;
        end
        if (u_advance) begin
            o_motion_reg <= motion;
            o_diff_reg   <= u_first_reg ? '0 : diff;
            o_mean_reg   <= new_entry.mean;
            o_var_reg    <= new_entry.variance;
        end
    end

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            gain_reg    <= GAIN_RESET;
            var_min_reg <= VAR_MIN_RESET;
            var_max_reg <= VAR_MAX_RESET;
        end else begin
            if (s_accept) begin
                u_valid_reg <= 1'b1;
                // entry being written this edge is missed by the RAM read
                fwd_hit_reg <= u_advance && (u_addr_reg == in_addr);
            end else if (u_advance) begin
                u_valid_reg <= 1'b0;
            end

            if (u_advance) begin
                o_valid_reg <= 1'b1;
            end else if (m_ready) begin
                o_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_GAIN:    gain_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_VAR_MIN: var_min_reg <= cfg_data;
                    CFG_VAR_MAX: var_max_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_motion       = o_motion_reg;
    assign m_difference   = o_diff_reg;
    assign m_mean_out     = o_mean_reg;
    assign m_variance_out = o_var_reg;

endmodule

`default_nettype wire
